[sv/pled_pkg.sv]
// shared types and register map constants for the pwm led driver
package pled_pkg;

  // kind of input beat, carried on the slave tuser
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 8;
  localparam int unsigned StageEnW = 24;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [DataW-1:0] byte_t;

  localparam addr_t ADDR_ENABLE_OUTPUT = 5'h00;
  localparam addr_t ADDR_DUTY_FIRST    = 5'h01;
  localparam addr_t ADDR_DUTY_LAST     = 5'h12;
  localparam addr_t ADDR_LEDS_FIRST    = 5'h13;
  localparam addr_t ADDR_LEDS_LAST     = 5'h15;
  localparam addr_t ADDR_UPDATE        = 5'h16;
  localparam addr_t ADDR_RESET         = 5'h17;

  // bit positions inside the master tuser
  localparam int unsigned UserOutputOn  = 0;
  localparam int unsigned UserAddrError = 1;

endpackage

[sv/pwm_led_driver_18_channel.sv]
// top level of the pwm led driver: register file, pwm compare and output register
//
// The driver takes one beat per cycle on the slave stream while s_axis_tready
// is high: either a register write (tuser = 0, tdata carries address and
// data byte) or a pwm tick (tuser = 1). Every accepted beat produces exactly
// one result beat on the master stream in the next cycle, holding the led pin
// pattern, the output enable state and an address error flag. Throughput is
// one beat per clock cycle unless the master stalls; the state update and the
// per-channel duty compare fit between input handshake and result register.
// s_axis_tready only drops while a result waits in the result register and
// the downstream side is not taking it. Writes to addresses 1..18 stage duty
// values, 19..21 stage enable bits eight channels per byte, 22 copies the
// staged values into the active set and 23 clears all state; addresses
// 24..31 change nothing and flag addr_error. On a tick the pins reflect the
// phase before it advances; on a write they reflect the state after the write.
module pwm_led_driver_18_channel #(
  parameter int unsigned CHANNELS = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [4:0] reg_addr, [12:5] reg_data
  input  logic                          s_axis_tuser,  // [0] command
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [((CHANNELS+7)/8)*8-1:0] m_axis_tdata,  // [CHANNELS-1:0] led_pins
  output logic [1:0]                    m_axis_tuser   // [0] output_on, [1] addr_error
);
  import pled_pkg::*;

  localparam int unsigned OutW = ((CHANNELS + 7) / 8) * 8;

  // state registers
  byte_t                 staged_duty_q [CHANNELS];
  byte_t                 staged_duty_d [CHANNELS];
  byte_t                 active_duty_q [CHANNELS];
  byte_t                 active_duty_d [CHANNELS];
  logic [StageEnW-1:0]   staged_en_q, staged_en_d;
  logic [CHANNELS-1:0]   active_en_q, active_en_d;
  logic                  out_en_q, out_en_d;
  byte_t                 phase_q, phase_d;

  // result register
  logic                  m_valid_q, m_valid_d;
  logic [CHANNELS-1:0]   pins_q, pins_d;
  logic                  err_q, err_d;

  logic   accept;
  cmd_e   cmd;
  addr_t  addr;
  byte_t  data;
  logic   is_write;
  logic   is_tick;

  // result register empties or drains this cycle
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cmd      = cmd_e'(s_axis_tuser);
  assign addr     = s_axis_tdata[AddrW-1:0];
  assign data     = s_axis_tdata[AddrW +: DataW];
  assign is_write = accept && (cmd == CMD_WRITE);
  assign is_tick  = accept && (cmd == CMD_TICK);

  // next state of the register file
  always_comb begin
    staged_duty_d = staged_duty_q;
    active_duty_d = active_duty_q;
    staged_en_d   = staged_en_q;
    active_en_d   = active_en_q;
    out_en_d      = out_en_q;
    phase_d       = phase_q;
    err_d         = 1'b0;

    if (is_tick) begin
      phase_d = phase_q + 8'd1;
    end

    if (is_write) begin
      if (addr == ADDR_ENABLE_OUTPUT) begin
        out_en_d = data[0];
      end else if (addr >= ADDR_DUTY_FIRST && addr <= ADDR_DUTY_LAST) begin
        // duty addresses past the channel count are taken and dropped
        for (int unsigned c = 0; c < CHANNELS; c++) begin
          if (addr == AddrW'(ADDR_DUTY_FIRST + c)) begin
            staged_duty_d[c] = data;
          end
        end
      end else if (addr >= ADDR_LEDS_FIRST && addr <= ADDR_LEDS_LAST) begin
        case (addr)
          ADDR_LEDS_FIRST:         staged_en_d[7:0]   = data;
          ADDR_LEDS_FIRST + 5'd1:  staged_en_d[15:8]  = data;
          default:                 staged_en_d[23:16] = data;
        endcase
      end else if (addr == ADDR_UPDATE) begin
        active_duty_d = staged_duty_q;
        active_en_d   = staged_en_q[CHANNELS-1:0];
      end else if (addr == ADDR_RESET) begin
        for (int unsigned c = 0; c < CHANNELS; c++) begin
          staged_duty_d[c] = '0;
          active_duty_d[c] = '0;
        end
        staged_en_d = '0;
        active_en_d = '0;
        out_en_d    = 1'b0;
        phase_d     = '0;
      end else begin
        err_d = 1'b1;
      end
    end
  end

  // pwm compare: state after a write, phase before a tick advances
  always_comb begin
    for (int unsigned c = 0; c < CHANNELS; c++) begin
      pins_d[c] = out_en_d && active_en_d[c] && (phase_q < active_duty_d[c]);
    end
  end

  // result register holds until the downstream side takes it
  assign m_valid_d = accept || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned c = 0; c < CHANNELS; c++) begin
        staged_duty_q[c] <= '0;
        active_duty_q[c] <= '0;
      end
      staged_en_q <= '0;
      active_en_q <= '0;
      out_en_q    <= 1'b0;
      phase_q     <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      staged_duty_q <= staged_duty_d;
      active_duty_q <= active_duty_d;
      staged_en_q   <= staged_en_d;
      active_en_q   <= active_en_d;
      out_en_q      <= out_en_d;
      phase_q       <= phase_d;
      m_valid_q     <= m_valid_d;
    end
  end

  // result payload, loaded only on an accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pins_q <= pins_d;
      err_q  <= err_d;
    end
  end

  logic out_on_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_on_q <= out_en_d;
    end
  end

  assign m_axis_tvalid                = m_valid_q;
  assign m_axis_tdata                 = OutW'(pins_q);
  assign m_axis_tuser[UserOutputOn]   = out_on_q;
  assign m_axis_tuser[UserAddrError]  = err_q;

endmodule

[sv/pled_checker.sv]
// port-level checker for the pwm led driver and its bind
module pled_checker #(
  parameter int unsigned CHANNELS = 18
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [15:0]                   s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [((CHANNELS+7)/8)*8-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);
  import pled_pkg::*;

  logic s_beat;
  assign s_beat = s_axis_tvalid && s_axis_tready;

  // a stalled result beat keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // shut down means every pin is off
  a_shutdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[UserOutputOn] |-> m_axis_tdata == '0)
    else $error("pins driven while outputs are shut down");

  // a tick never reports an address error
  a_tick_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && s_axis_tuser == CMD_TICK |=>
      m_axis_tvalid && !m_axis_tuser[UserAddrError])
    else $error("address error on a tick");

  // a write above the register map is flagged
  a_bad_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && s_axis_tuser == CMD_WRITE && s_axis_tdata[4:3] == 2'b11 |=>
      m_axis_tvalid && m_axis_tuser[UserAddrError])
    else $error("undefined address not flagged");

endmodule

bind pwm_led_driver_18_channel pled_checker #(.CHANNELS(CHANNELS)) u_pled_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/pled_pin_checker.sv]
// result checker for the pwm led driver: tracks driver state from input beats and compares result beats
module pled_pin_checker #(
  parameter int unsigned CHANNELS = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [15:0]                   s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [((CHANNELS+7)/8)*8-1:0] m_tdata,
  input  logic [1:0]                    m_tuser,
  output int                            mismatches,
  output int                            frames_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import pled_pkg::*;

  localparam int unsigned DutyRegs = ADDR_DUTY_LAST - ADDR_DUTY_FIRST + 1;
  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [CHANNELS-1:0] pins;
    logic                output_on;
    logic                addr_error;
  } pin_frame_t;

  byte_t                 staged_duty [DutyRegs];
  byte_t                 active_duty [DutyRegs];
  logic [StageEnW-1:0]   staged_en;
  logic [CHANNELS-1:0]   active_en;
  logic                  out_en;
  byte_t                 phase;
  pin_frame_t            pin_frames_due [$];
  int                    fail_total;

  initial begin
    fail_total = 0;
  end

  function automatic void clear_state();
    foreach (staged_duty[i]) begin
      staged_duty[i] = '0;
      active_duty[i] = '0;
    end
    staged_en = '0;
    active_en = '0;
    out_en    = 1'b0;
    phase     = '0;
  endfunction

  function automatic logic [CHANNELS-1:0] lit_pins();
    logic [CHANNELS-1:0] p;
    p = '0;
    if (out_en) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (active_en[c] && phase < active_duty[c]) p[c] = 1'b1;
      end
    end
    return p;
  endfunction

  // advance the driver state by one beat and return the result it must produce
  function automatic pin_frame_t apply_beat(cmd_e cmd, addr_t a, byte_t d);
    pin_frame_t f;
    int         idx;
    f.addr_error = 1'b0;
    if (cmd == CMD_TICK) begin
      // pins come from the phase before it moves on
      f.pins = lit_pins();
      phase  = phase + 8'd1;
    end else begin
      if (a == ADDR_ENABLE_OUTPUT) begin
        out_en = d[0];
      end else if (a >= ADDR_DUTY_FIRST && a <= ADDR_DUTY_LAST) begin
        idx = int'(a) - int'(ADDR_DUTY_FIRST);
        if (idx < CHANNELS) staged_duty[idx] = d;
      end else if (a >= ADDR_LEDS_FIRST && a <= ADDR_LEDS_LAST) begin
        idx = (int'(a) - int'(ADDR_LEDS_FIRST)) * 8;
        staged_en[idx +: 8] = d;
      end else if (a == ADDR_UPDATE) begin
        // enable bits past the last channel are dropped here
        active_duty = staged_duty;
        active_en   = staged_en[CHANNELS-1:0];
      end else if (a == ADDR_RESET) begin
        clear_state();
      end else begin
        f.addr_error = 1'b1;
      end
      f.pins = lit_pins();
    end
    f.output_on = out_en;
    return f;
  endfunction

  task automatic flag_mismatch(string what, pin_frame_t want, pin_frame_t got);
    fail_total++;
    if (fail_total <= ReportMax) begin
      $display("%0t ns: %s: expected pins %05h on %0b err %0b, got pins %05h on %0b err %0b",
               $time, what, want.pins, want.output_on, want.addr_error,
               got.pins, got.output_on, got.addr_error);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pin_frame_t got;
    pin_frame_t want;
    if (!rst_ni) begin
      clear_state();
      pin_frames_due.delete();
      frames_waiting <= 0;
      mismatches     <= fail_total;
    end else begin
      if (s_tvalid && s_tready) begin
        pin_frames_due.push_back(apply_beat(cmd_e'(s_tuser), s_tdata[4:0], s_tdata[12:5]));
      end
      if (m_tvalid && m_tready) begin
        got.pins       = m_tdata[CHANNELS-1:0];
        got.output_on  = m_tuser[UserOutputOn];
        got.addr_error = m_tuser[UserAddrError];
        if (pin_frames_due.size() == 0) begin
          flag_mismatch("result beat with nothing outstanding", '0, got);
        end else begin
          want = pin_frames_due.pop_front();
          if (got.pins !== want.pins || got.output_on !== want.output_on ||
              got.addr_error !== want.addr_error) begin
            flag_mismatch("result mismatch", want, got);
          end
        end
      end
      frames_waiting <= pin_frames_due.size();
      mismatches     <= fail_total;
    end
  end

endmodule

[tb/tb_pwm_led_driver_18_channel.sv]
// testbench top for the pwm led driver: clock, reset, stimulus, backpressure and verdict
module tb_pwm_led_driver_18_channel;
  timeunit 1ns;
  timeprecision 1ps;

  import pled_pkg::*;

  localparam int unsigned CHANNELS      = 18;
  localparam int unsigned OutW          = ((CHANNELS + 7) / 8) * 8;
  localparam int          DirectedBeats = 22;
  localparam int          RandomBeats   = 528;
  localparam int          HoldOffCycles = 64;
  localparam int          DrainLimit    = 2000;

  // addresses outside the register map
  localparam addr_t ADDR_UNDEF_FIRST = ADDR_RESET + 5'd1;
  localparam addr_t ADDR_UNDEF_LAST  = 5'h1F;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // [4:0] reg_addr, [12:5] reg_data
  logic              s_axis_tuser;   // [0] command
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OutW-1:0]   m_axis_tdata;   // [17:0] led_pins
  logic [1:0]        m_axis_tuser;   // [0] output_on, [1] addr_error

  int                mismatches;
  int                frames_waiting;
  int                beats_sent;
  int                burst_left;
  logic              squeeze_req;

  pwm_led_driver_18_channel #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // watches both streams, predicts every result beat and counts mismatches
  pled_pin_checker #(
    .CHANNELS(CHANNELS)
  ) u_pin_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid      (s_axis_tvalid),
    .s_tready      (s_axis_tready),
    .s_tdata       (s_axis_tdata),
    .s_tuser       (s_axis_tuser),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_tdata       (m_axis_tdata),
    .m_tuser       (m_axis_tuser),
    .mismatches    (mismatches),
    .frames_waiting(frames_waiting)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the handshakes lock up
  initial begin
    #200_000;
    $display("Regression FAIL");
    $finish;
  end

  // offer one beat; the sender runs in bursts, and a new burst starts after a random gap
  task automatic send_beat(cmd_e cmd, addr_t a, byte_t d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, d, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  // mostly random duty values, with the extremes often enough to matter
  function automatic byte_t pick_duty();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    if (sel == 2) return 8'h01;
    return byte_t'($urandom);
  endfunction

  // receiver: random stall density, redrawn each time its mode length runs out,
  // plus one long hold-off requested by the stimulus
  initial begin
    int hold_left;
    int mode_left;
    int stall_pct;
    bit squeeze_done;
    hold_left    = 0;
    mode_left    = 0;
    stall_pct    = 0;
    squeeze_done = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = HoldOffCycles;
      end
      if (hold_left > 0) begin
        // the sender keeps offering, so the block fills and drops tready
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
          mode_left = $urandom_range(10, 60);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        mode_left--;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int    duty_writes;
    int    en_writes;
    int    run_len;
    int    drain_cycles;
    byte_t en_data;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = CMD_WRITE;
    s_axis_tdata  = '0;
    beats_sent    = 0;
    burst_left    = 0;
    squeeze_req   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    send_beat(CMD_TICK,  '0, '0);                           // tick straight out of reset
    send_beat(CMD_WRITE, ADDR_ENABLE_OUTPUT, 8'hFE);        // only bit 0 counts: stays off
    send_beat(CMD_WRITE, ADDR_ENABLE_OUTPUT, 8'h01);        // outputs on
    send_beat(CMD_WRITE, ADDR_DUTY_FIRST, 8'hFF);           // channel 0 full duty
    send_beat(CMD_WRITE, ADDR_DUTY_FIRST + 5'd1, 8'h00);    // channel 1 zero duty
    send_beat(CMD_WRITE, ADDR_DUTY_LAST, 8'h01);            // last channel minimal duty
    send_beat(CMD_WRITE, ADDR_LEDS_FIRST, 8'hFF);
    send_beat(CMD_WRITE, ADDR_LEDS_FIRST + 5'd1, 8'hFF);
    send_beat(CMD_WRITE, ADDR_LEDS_LAST, 8'hFF);            // bits past channel 17 get staged
    send_beat(CMD_WRITE, ADDR_UPDATE, 8'hAA);               // data on update is ignored
    send_beat(CMD_TICK,  '0, '0);                           // phase 1, last channel drops
    send_beat(CMD_TICK,  '0, '0);                           // phase 2
    send_beat(CMD_WRITE, ADDR_UNDEF_FIRST, 8'h00);          // undefined address
    send_beat(CMD_WRITE, ADDR_UNDEF_LAST, 8'hFF);
    send_beat(CMD_TICK,  ADDR_UNDEF_LAST, 8'hFF);           // fields ignored on a tick
    send_beat(CMD_WRITE, ADDR_LEDS_LAST, 8'h00);
    send_beat(CMD_WRITE, ADDR_UPDATE, 8'h55);
    send_beat(CMD_TICK,  '0, '0);
    send_beat(CMD_WRITE, ADDR_ENABLE_OUTPUT, 8'h00);        // shut down
    send_beat(CMD_TICK,  '0, '0);
    send_beat(CMD_WRITE, ADDR_RESET, 8'h5A);                // clear everything, data ignored
    send_beat(CMD_TICK,  '0, '0);

    // random part: program a pattern, commit it, run ticks; some noise in between
    squeeze_req = 1'b1;
    while (beats_sent < DirectedBeats + RandomBeats) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any command at any address, resets and undefined addresses included
        repeat ($urandom_range(1, 4)) begin
          send_beat(cmd_e'($urandom_range(0, 1)), addr_t'($urandom_range(0, 31)),
                    byte_t'($urandom));
        end
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          send_beat(CMD_WRITE, ADDR_ENABLE_OUTPUT,
                    {7'($urandom), ($urandom_range(0, 99) < 85)});
        end
        duty_writes = $urandom_range(0, 8);
        repeat (duty_writes) begin
          send_beat(CMD_WRITE, addr_t'($urandom_range(ADDR_DUTY_FIRST, ADDR_DUTY_LAST)),
                    pick_duty());
        end
        en_writes = $urandom_range(0, 3);
        repeat (en_writes) begin
          case ($urandom_range(0, 3))
            0: en_data = 8'hFF;
            1: en_data = 8'h00;
            default: en_data = byte_t'($urandom);
          endcase
          send_beat(CMD_WRITE, addr_t'($urandom_range(ADDR_LEDS_FIRST, ADDR_LEDS_LAST)),
                    en_data);
        end
        if ($urandom_range(0, 9) != 0) send_beat(CMD_WRITE, ADDR_UPDATE, byte_t'($urandom));
        // occasionally a run long enough to wrap the phase
        run_len = ($urandom_range(0, 11) == 0) ? $urandom_range(256, 270) : $urandom_range(1, 40);
        // a long run may go past the item budget by at most 270 beats
        if (run_len > 40 && beats_sent + run_len > DirectedBeats + RandomBeats + 270) begin
          run_len = $urandom_range(1, 40);
        end
        repeat (run_len) begin
          if (run_len > 40 || beats_sent < DirectedBeats + RandomBeats) begin
            send_beat(CMD_TICK, addr_t'($urandom), byte_t'($urandom));
          end
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain: wait for every outstanding result before the verdict
    drain_cycles = 0;
    while (frames_waiting != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && frames_waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/pled_pkg.sv
sv/pwm_led_driver_18_channel.sv
sv/pled_checker.sv
tb/pled_pin_checker.sv
tb/tb_pwm_led_driver_18_channel.sv
